[src/mtq_pkg.sv]
package mtq_pkg;

  // fixed field widths
  localparam int unsigned CmdW   = 1;
  localparam int unsigned ChanW  = 6;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned ValW   = 16;
  localparam int unsigned LvlW   = 5;
  localparam int unsigned ResW   = 21;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // default sizes
  localparam int unsigned DefChannels      = 64;
  localparam int unsigned DefMaxThresholds = 16;

  // command codes
  localparam logic [CmdW-1:0] CMD_LOAD    = 1'b0;
  localparam logic [CmdW-1:0] CMD_PROCESS = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_THR_IN_USE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SHARED     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SCALE      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BIAS       = 3'd3;

  // register reset values
  localparam logic [LvlW-1:0]        RST_THR_IN_USE = 5'd16;
  localparam logic                   RST_SHARED     = 1'b0;
  localparam logic signed [ValW-1:0] RST_SCALE      = 16'sd256;
  localparam logic signed [ValW-1:0] RST_BIAS       = 16'sd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MUL,
    ST_OUT
  } mtq_state_e;

endpackage

[src/multi_threshold_quantizer_core.sv]
// multi-threshold quantizer
// input channel: in_valid_i / in_stall_o with cmd, channel, slot, value.
//   a load word (cmd 0) writes one threshold into row channel, position slot
//   of the threshold memory in the cycle it is accepted and gives no result.
//   a process word (cmd 1) counts the thresholds of its row (row 0 in shared
//   mode) that the sample strictly exceeds and returns level and
//   level * scale + bias, saturated to 21 bits signed Q13.8.
// output channel: out_valid_o / out_stall_i with level and result, held in
//   an output register, so a new word is taken while a result waits.
// config channel: cfg_valid_i / cfg_ready_o, always ready; index 0 selects
//   thresholds in use, 1 shared mode, 2 scale, 3 bias, others are ignored.
// sequencing: one comparator reads one stored threshold per cycle from a
//   memory with a single registered read port. a process word with n
//   thresholds in use passes through a scan that reads each threshold in
//   use, then the drain, multiply and out states (n = 0 skips scan and drain),
//   and the next word is taken once the state is back in idle. a load word leaves the block idle.
// if the receiver stalls, a finished result waits in the last stage until
//   the output register frees up; in_stall_o stays high meanwhile.
// reset clears the control state and restores the register defaults; the
//   threshold memory holds no defined content until written.
module multi_threshold_quantizer_core #(
  parameter int unsigned CHANNELS       = mtq_pkg::DefChannels,
  parameter int unsigned MAX_THRESHOLDS = mtq_pkg::DefMaxThresholds
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [mtq_pkg::CmdW-1:0]             in_cmd_i,
  input  logic [mtq_pkg::ChanW-1:0]            in_channel_i,
  input  logic [mtq_pkg::SlotW-1:0]            in_slot_i,
  input  logic signed [mtq_pkg::ValW-1:0]      in_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [mtq_pkg::LvlW-1:0]             out_level_o,
  output logic signed [mtq_pkg::ResW-1:0]      out_result_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mtq_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [mtq_pkg::CfgDataW-1:0]         cfg_data_i
);

  localparam int unsigned Depth = CHANNELS * MAX_THRESHOLDS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned RowW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned NCap  = (MAX_THRESHOLDS < 31) ? MAX_THRESHOLDS : 31;
  localparam int unsigned LutN  = 2 ** mtq_pkg::ChanW;
  localparam int unsigned ProdW = mtq_pkg::LvlW + 1 + mtq_pkg::ValW;
  localparam int unsigned SumW  = ProdW + 1;
  localparam logic signed [SumW-1:0] ResMax = SumW'(1048575);
  localparam logic signed [SumW-1:0] ResMin = -SumW'(1048576);

  // configuration registers
  logic [mtq_pkg::LvlW-1:0]        thr_in_use_q;
  logic                            shared_q;
  logic signed [mtq_pkg::ValW-1:0] scale_q;
  logic signed [mtq_pkg::ValW-1:0] bias_q;

  mtq_pkg::mtq_state_e state_q, state_d;

  logic [AddrW-1:0]                base_q;
  logic [mtq_pkg::LvlW-1:0]        n_q;
  logic [mtq_pkg::LvlW-1:0]        cnt_q;
  logic [mtq_pkg::LvlW-1:0]        lvl_q;
  logic signed [mtq_pkg::ValW-1:0] sample_q;
  logic                            rd_vld_q;
  logic signed [ProdW-1:0]         prod_q;
  logic                            out_vld_q;
  logic [mtq_pkg::LvlW-1:0]        out_lvl_q;
  logic signed [mtq_pkg::ResW-1:0] out_res_q;

  logic                            in_acc;
  logic                            proc_acc;
  logic                            wr_en;
  logic [AddrW-1:0]                wr_addr;
  logic                            rd_en;
  logic [AddrW-1:0]                rd_addr;
  logic signed [mtq_pkg::ValW-1:0] rd_data;
  logic [RowW-1:0]                 row_lut [LutN];
  logic [RowW-1:0]                 row_sel;
  logic [mtq_pkg::LvlW-1:0]        n_sel;
  logic                            out_load;
  logic signed [SumW-1:0]          sum;
  logic signed [mtq_pkg::ResW-1:0] res_sat;

  // channel modulo CHANNELS as a constant table
  for (genvar c = 0; c < LutN; c++) begin : g_row_lut
    assign row_lut[c] = RowW'(c % CHANNELS);
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_in_use_q <= mtq_pkg::RST_THR_IN_USE;
      shared_q     <= mtq_pkg::RST_SHARED;
      scale_q      <= mtq_pkg::RST_SCALE;
      bias_q       <= mtq_pkg::RST_BIAS;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mtq_pkg::REG_THR_IN_USE: thr_in_use_q <= cfg_data_i[mtq_pkg::LvlW-1:0];
        mtq_pkg::REG_SHARED:     shared_q     <= cfg_data_i[0];
        mtq_pkg::REG_SCALE:      scale_q      <= signed'(cfg_data_i);
        mtq_pkg::REG_BIAS:       bias_q       <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign in_acc   = in_valid_i && !in_stall_o;
  assign proc_acc = in_acc && (in_cmd_i == mtq_pkg::CMD_PROCESS);

  // load word: write straight into the table when row and slot exist
  assign wr_en = in_acc && (in_cmd_i == mtq_pkg::CMD_LOAD)
              && (32'(in_channel_i) < CHANNELS) && (32'(in_slot_i) < MAX_THRESHOLDS);
  assign wr_addr = AddrW'(int'(in_channel_i) * MAX_THRESHOLDS + int'(in_slot_i));

  assign row_sel = shared_q ? '0 : row_lut[in_channel_i];
  assign n_sel   = (32'(thr_in_use_q) > MAX_THRESHOLDS) ? mtq_pkg::LvlW'(NCap)
                                                         : thr_in_use_q;

  assign rd_addr = base_q + AddrW'(cnt_q);

  mtq_thr_mem #(
    .Depth(Depth)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(in_value_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign sum = {prod_q[ProdW-1], prod_q}
             + {{(SumW - mtq_pkg::ValW){bias_q[mtq_pkg::ValW-1]}}, bias_q};

  always_comb begin
    if (sum > ResMax) begin
      res_sat = ResMax[mtq_pkg::ResW-1:0];
    end else if (sum < ResMin) begin
      res_sat = ResMin[mtq_pkg::ResW-1:0];
    end else begin
      res_sat = sum[mtq_pkg::ResW-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mtq_pkg::ST_IDLE: begin
        if (proc_acc) begin
          state_d = (n_sel == '0) ? mtq_pkg::ST_MUL : mtq_pkg::ST_SCAN;
        end
      end
      mtq_pkg::ST_SCAN: begin
        if (cnt_q == n_q - 1'b1) begin
          state_d = mtq_pkg::ST_DRAIN;
        end
      end
      mtq_pkg::ST_DRAIN: state_d = mtq_pkg::ST_MUL;
      mtq_pkg::ST_MUL:   state_d = mtq_pkg::ST_OUT;
      mtq_pkg::ST_OUT: begin
        if (!out_vld_q || !out_stall_i) begin
          state_d = mtq_pkg::ST_IDLE;
        end
      end
      default: state_d = mtq_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      mtq_pkg::ST_IDLE: in_stall_o = 1'b0;
      mtq_pkg::ST_SCAN: rd_en = 1'b1;
      mtq_pkg::ST_OUT:  out_load = !out_vld_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mtq_pkg::ST_IDLE;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_acc) begin
      base_q   <= AddrW'(int'(row_sel) * MAX_THRESHOLDS);
      n_q      <= n_sel;
      sample_q <= in_value_i;
      cnt_q    <= '0;
      lvl_q    <= '0;
    end else begin
      if (rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end
      // compare the word read in the previous cycle
      if (rd_vld_q && (sample_q > rd_data)) begin
        lvl_q <= lvl_q + 1'b1;
      end
    end
    if (state_q == mtq_pkg::ST_MUL) begin
      prod_q <= signed'({1'b0, lvl_q}) * scale_q;
    end
    if (out_load) begin
      out_lvl_q <= lvl_q;
      out_res_q <= res_sat;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_level_o  = out_lvl_q;
  assign out_result_o = out_res_q;

  a_rd_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q) == mtq_pkg::ST_SCAN)
    else $error("threshold read data valid outside a scan");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mtq_pkg::ST_SCAN |-> cnt_q < n_q)
    else $error("scan counter past thresholds in use");

  a_lvl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mtq_pkg::ST_MUL |-> lvl_q <= n_q)
    else $error("level exceeds thresholds in use");

  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_vld_q && state_q == mtq_pkg::ST_IDLE)
    else $error("finished result not presented");

endmodule

[src/mtq_thr_mem.sv]
module mtq_thr_mem #(
  parameter int unsigned Depth = mtq_pkg::DefChannels * mtq_pkg::DefMaxThresholds,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                                clk_i,
  input  logic                                wr_en_i,
  input  logic [AddrW-1:0]                    wr_addr_i,
  input  logic signed [mtq_pkg::ValW-1:0]     wr_data_i,
  input  logic                                rd_en_i,
  input  logic [AddrW-1:0]                    rd_addr_i,
  output logic signed [mtq_pkg::ValW-1:0]     rd_data_o
);

  logic signed [mtq_pkg::ValW-1:0] mem_q [Depth];
  logic signed [mtq_pkg::ValW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[verif/mtq_checker.sv]
module mtq_checker
  import mtq_pkg::*;
#(
  parameter int unsigned CHANNELS       = DefChannels,
  parameter int unsigned MAX_THRESHOLDS = DefMaxThresholds
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [CmdW-1:0]        cmd_i,
  input  logic [ChanW-1:0]       channel_i,
  input  logic [SlotW-1:0]       slot_i,
  input  logic signed [ValW-1:0] value_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [LvlW-1:0]        level_i,
  input  logic signed [ResW-1:0] result_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  output int                     mismatches_o,
  output int                     outstanding_o
);

  localparam int ResMax = 2 ** (ResW - 1) - 1;
  localparam int ResMin = -(2 ** (ResW - 1));

  typedef struct packed {
    logic [LvlW-1:0]        level;
    logic signed [ResW-1:0] result;
  } quant_word_t;

  quant_word_t            quant_queue[$];
  logic signed [ValW-1:0] thr_mem [CHANNELS][MAX_THRESHOLDS];
  logic [LvlW-1:0]        thr_in_use;
  logic                   shared_q;
  logic signed [ValW-1:0] scale_q;
  logic signed [ValW-1:0] bias_q;
  int                     mismatch_cnt = 0;

  assign mismatches_o = mismatch_cnt;

  function automatic quant_word_t quantize_sample(logic [ChanW-1:0] chan,
                                                  logic signed [ValW-1:0] sample);
    int          n;
    int          row;
    int          count;
    int          acc;
    quant_word_t w;
    n = (thr_in_use > MAX_THRESHOLDS) ? MAX_THRESHOLDS : thr_in_use;
    row = shared_q ? 0 : chan % CHANNELS;
    count = 0;
    for (int t = 0; t < n; t++) begin
      if (sample > thr_mem[row][t]) count++;
    end
    acc = count * int'(scale_q) + int'(bias_q);
    if (acc > ResMax) acc = ResMax;
    if (acc < ResMin) acc = ResMin;
    w.level = count[LvlW-1:0];
    w.result = acc[ResW-1:0];
    return w;
  endfunction

  task automatic report_mismatch(string what, logic signed [31:0] got,
                                 logic signed [31:0] want);
    $display("[%0t] quantizer mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    quant_word_t want;
    if (!rst_ni) begin
      quant_queue.delete();
      thr_in_use = RST_THR_IN_USE;
      shared_q = RST_SHARED;
      scale_q = RST_SCALE;
      bias_q = RST_BIAS;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (quant_queue.size() == 0) begin
          report_mismatch("result word with no sample waiting", result_i, 0);
        end else begin
          want = quant_queue.pop_front();
          if (level_i !== want.level) report_mismatch("level", level_i, want.level);
          if (result_i !== want.result) report_mismatch("result", result_i, want.result);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_THR_IN_USE: thr_in_use = cfg_data_i[LvlW-1:0];
          REG_SHARED:     shared_q = cfg_data_i[0];
          REG_SCALE:      scale_q = signed'(cfg_data_i);
          REG_BIAS:       bias_q = signed'(cfg_data_i);
          default:        ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (cmd_i == CMD_LOAD) begin
          if (channel_i < CHANNELS && slot_i < MAX_THRESHOLDS) begin
            thr_mem[channel_i][slot_i] = value_i;
          end
        end else begin
          quant_queue.push_back(quantize_sample(channel_i, value_i));
        end
      end
    end
    outstanding_o = quant_queue.size();
  end

endmodule

[verif/testbench.sv]
module testbench;
  import mtq_pkg::*;

  localparam int IdleLimit     = 4000;
  localparam int SettleCycles  = 40;
  localparam int NumPhases     = 9;
  localparam int ItemsPerPhase = 185;
  localparam int HoldOffCycles = 300;
  localparam logic signed [ValW-1:0] VAL_MIN = 16'sh8000;
  localparam logic signed [ValW-1:0] VAL_MAX = 16'sh7fff;
  localparam logic [CfgIdxW-1:0] REG_FIRST_UNUSED = REG_BIAS + 1'b1;

  typedef struct packed {
    logic [LvlW-1:0]     in_use;
    logic                shared;
    logic [CfgDataW-1:0] scale;
    logic [CfgDataW-1:0] bias;
  } qsetting_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [CmdW-1:0]        in_cmd_i = CMD_LOAD;
  logic [ChanW-1:0]       in_channel_i = '0;
  logic [SlotW-1:0]       in_slot_i = '0;
  logic signed [ValW-1:0] in_value_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [LvlW-1:0]        out_level_o;
  logic signed [ResW-1:0] out_result_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxW-1:0]     cfg_index_i = '0;
  logic [CfgDataW-1:0]    cfg_data_i = '0;

  int mismatches;
  int outstanding;

  // stimulus-side view of the threshold table, so no sample reads an unwritten entry
  bit                     loaded [DefChannels][DefMaxThresholds];
  logic signed [ValW-1:0] shadow [DefChannels][DefMaxThresholds];
  logic signed [ValW-1:0] corner_thr [DefMaxThresholds];
  logic [ChanW-1:0]       hot_chan [8];
  qsetting_t              plan [NumPhases];
  int                     cur_n = DefMaxThresholds;
  bit                     cur_shared = 1'b0;
  bit                     calm = 1'b0;

  always #2 clk_i = ~clk_i;

  multi_threshold_quantizer_core dut (.*);

  mtq_checker quant_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .cmd_i        (in_cmd_i),
    .channel_i    (in_channel_i),
    .slot_i       (in_slot_i),
    .value_i      (in_value_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .level_i      (out_level_o),
    .result_i     (out_result_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  task automatic send_word(logic [CmdW-1:0] cmd, logic [ChanW-1:0] chan,
                           logic [SlotW-1:0] slot, logic signed [ValW-1:0] v);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_cmd_i <= cmd;
    in_channel_i <= chan;
    in_slot_i <= slot;
    in_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic load_threshold(int chan, int slot, logic signed [ValW-1:0] v);
    send_word(CMD_LOAD, ChanW'(chan), SlotW'(slot), v);
    loaded[chan][slot] = 1'b1;
    shadow[chan][slot] = v;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_setting(qsetting_t s);
    // junk in the unused upper bits of the narrow registers
    write_reg(REG_THR_IN_USE, {11'($urandom), s.in_use});
    write_reg(REG_SHARED, {15'($urandom), s.shared});
    write_reg(REG_SCALE, s.scale);
    write_reg(REG_BIAS, s.bias);
    write_reg(CfgIdxW'($urandom_range(REG_FIRST_UNUSED, 2 ** CfgIdxW - 1)), 16'($urandom));
    cfg_valid_i <= 1'b0;
    cur_n = (s.in_use > DefMaxThresholds) ? DefMaxThresholds : s.in_use;
    cur_shared = s.shared;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic signed [ValW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:             return VAL_MIN;
      1:             return VAL_MAX;
      2, 3, 4, 5, 6: return 16'($urandom_range(0, 127)) - 16'd64;
      default:       return 16'($urandom);
    endcase
  endfunction

  // samples near stored thresholds exercise the strict comparison
  function automatic logic signed [ValW-1:0] pick_sample(int row);
    int                     r;
    logic signed [ValW-1:0] near;
    r = $urandom_range(0, 9);
    if (r > 2 || cur_n == 0) return pick_value();
    near = shadow[row][$urandom_range(0, cur_n - 1)];
    if (r == 1) return near + 16'sd1;
    if (r == 2) return near - 16'sd1;
    return near;
  endfunction

  task automatic random_word();
    int chan;
    int row;
    int missing;
    if ($urandom_range(0, 3) == 0) begin
      load_threshold($urandom_range(0, DefChannels - 1), $urandom_range(0, DefMaxThresholds - 1),
                     pick_value());
    end else begin
      chan = ($urandom_range(0, 3) != 0) ? int'(hot_chan[$urandom_range(0, 7)])
                                         : $urandom_range(0, DefChannels - 1);
      row = cur_shared ? 0 : chan;
      missing = -1;
      for (int t = 0; t < cur_n; t++) begin
        if (!loaded[row][t] && missing < 0) missing = t;
      end
      if (missing >= 0) load_threshold(row, missing, pick_value());
      else send_word(CMD_PROCESS, ChanW'(chan), 4'($urandom), pick_sample(row));
    end
  endtask

  initial begin
    corner_thr = '{VAL_MIN, VAL_MAX, 0, -1, 1, 2, -2, 100, -100, 16'sh5555, 16'shaaaa,
                   1000, -1000, 7, -7, 0};
    hot_chan[0] = '0;
    hot_chan[1] = '1;
    for (int h = 2; h < 8; h++) hot_chan[h] = 6'($urandom);
    plan[0] = '{5'd16, 1'b0, 16'd256, 16'd0};
    plan[1] = '{5'd0, 1'b0, 16'($urandom), 16'($urandom)};
    plan[2] = '{5'd31, 1'b1, 16'h8000, 16'h8000};
    plan[3] = '{5'd1, 1'b0, 16'h7fff, 16'h7fff};
    plan[4] = '{5'd8, 1'b1, 16'($urandom), 16'($urandom)};
    plan[5] = '{5'd17, 1'b0, 16'hffff, 16'h0000};
    plan[6] = '{5'($urandom), 1'($urandom), 16'($urandom), 16'($urandom)};
    plan[7] = '{5'd16, 1'b0, 16'h8000, 16'h7fff};
    plan[8] = '{5'd5, 1'b0, 16'h7fff, 16'h8000};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner thresholds in row 0, then samples against them at reset settings
    for (int s = 0; s < DefMaxThresholds; s++) load_threshold(0, s, corner_thr[s]);
    send_word(CMD_PROCESS, '0, '0, VAL_MIN);
    send_word(CMD_PROCESS, '0, '1, VAL_MAX);
    send_word(CMD_PROCESS, '0, '0, 16'sd0);
    send_word(CMD_PROCESS, '0, '0, -16'sd1);
    send_word(CMD_PROCESS, '0, '0, 16'sd1);
    send_word(CMD_PROCESS, '0, '0, 16'sd100);
    settle();

    for (int p = 0; p < NumPhases; p++) begin
      apply_setting(plan[p]);
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if (i % 48 == 0) calm = ($urandom_range(0, 3) == 0);
        random_word();
      end
      settle();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result side: random stall per word, and two long hold-offs to back up the block
  initial begin : sink
    int taken;
    int hold;
    taken = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        taken++;
        if (taken == 120 || taken == 600) hold = HoldOffCycles;
        else hold = calm ? 0 : $urandom_range(0, 7);
        if (hold > 0) begin
          out_stall_i <= 1'b1;
          repeat (hold) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Verification failed");
    $finish;
  end

endmodule
